@@ src/morse_table_decoder_macros.svh @@
// Assertion macros used by the Morse table decoder top level.
`ifndef MORSE_TABLE_DECODER_MACROS_SVH
`define MORSE_TABLE_DECODER_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define MTD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Checks that cons holds in the cycle after ante.
`define MTD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ src/mtd_pkg.sv @@
// Package with the codes and constants of the Morse table decoder.
package mtd_pkg;

    localparam int MAX_DEPTH_DEF = 6;
    localparam int PATH_W        = 6;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [1:0] SYM_DOT = 2'd0;
    localparam logic [1:0] SYM_DASH = 2'd1;
    localparam logic [1:0] SYM_SEP = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_LETTER = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

endpackage

@@ src/morse_table_decoder.sv @@
// Morse decoder top level: tree walk over a heap-indexed letter table.
//
// The block takes one request per cycle. A dot or dash shifts the walk index,
// a load writes the letter table and a clear drops every valid bit, so none
// of these stalls. A letter separator reads the table at the walk index; its
// result passes through the table's registered read port and then through
// the output register. The input stalls only while both the read-result
// stage and the output register hold results that are not taken.
`include "morse_table_decoder_macros.svh"

module morse_table_decoder
    import mtd_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // symbol, letter, path_bits, path_length, zero pad
    input  logic [1:0]  s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // decoded_letter
    output logic [1:0]  m_tuser   // status
);

    localparam int IDX_W = MAX_DEPTH + 1;

    logic [1:0]       in_mode;
    logic [1:0]       in_symbol;
    logic [7:0]       in_letter;
    logic [5:0]       in_path_bits;
    logic [2:0]       in_path_length;

    logic [IDX_W-1:0] walk_index_reg;
    logic [IDX_W-1:0] walk_index_next;
    logic             too_long_reg;
    logic             too_long_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_too_long_reg;

    logic             m_tvalid_reg;
    logic [7:0]       m_letter_reg;
    logic [1:0]       m_status_reg;

    logic             accept;
    logic             out_free;
    logic             s1_move;
    logic             is_step;
    logic             is_sep;
    logic             sep_emit;
    logic             load_ok;
    logic [IDX_W-1:0] load_index;
    logic [IDX_W+PATH_W-1:0] bits_ext;

    logic [7:0]       tbl_rd_data;
    logic             tbl_rd_hit;
    logic [1:0]       s1_status;

    assign in_symbol      = s_tdata[1:0];
    assign in_letter      = s_tdata[9:2];
    assign in_path_bits   = s_tdata[15:10];
    assign in_path_length = s_tdata[18:16];
    assign in_mode        = s_tuser;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign is_step  = (in_mode == MODE_DECODE) &&
                      ((in_symbol == SYM_DOT) || (in_symbol == SYM_DASH));
    assign is_sep   = (in_mode == MODE_DECODE) && (in_symbol == SYM_SEP);
    assign sep_emit = accept && is_sep &&
                      !((walk_index_reg == IDX_W'(1)) && !too_long_reg);

    assign bits_ext = {{IDX_W{1'b0}}, in_path_bits};
    assign load_ok  = int'(in_path_length) <= MAX_DEPTH;

    always_comb begin
        for (int i = 0; i < IDX_W; i++) begin
            load_index[i] = (i == int'(in_path_length)) ||
                            ((i < int'(in_path_length)) && bits_ext[i]);
        end
    end

    always_comb begin
        walk_index_next = walk_index_reg;
        too_long_next   = too_long_reg;
        if (accept && is_step) begin
            if (walk_index_reg[IDX_W-1]) begin
                too_long_next = 1'b1;
            end else begin
                walk_index_next = {walk_index_reg[IDX_W-2:0], in_symbol[0]};
            end
        end else if (accept && is_sep) begin
            walk_index_next = IDX_W'(1);
            too_long_next   = 1'b0;
        end
    end

    assign s1_valid_next = sep_emit || (s1_valid_reg && !s1_move);

    mtd_table #(
        .IDX_W(IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (accept && (in_mode == MODE_CLEAR)),
        .wr_en   (accept && (in_mode == MODE_LOAD) && load_ok),
        .wr_addr (load_index),
        .wr_data (in_letter),
        .rd_en   (sep_emit),
        .rd_addr (walk_index_reg),
        .rd_data (tbl_rd_data),
        .rd_hit  (tbl_rd_hit)
    );

    always_comb begin
        if (s1_too_long_reg) begin
            s1_status = STATUS_TOO_LONG;
        end else if (!tbl_rd_hit) begin
            s1_status = STATUS_NO_LETTER;
        end else begin
            s1_status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_index_reg <= IDX_W'(1);
            too_long_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            walk_index_reg <= walk_index_next;
            too_long_reg   <= too_long_next;
            s1_valid_reg   <= s1_valid_next;
            if (s1_move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sep_emit) begin
            s1_too_long_reg <= too_long_reg;
        end
        if (s1_move) begin
            m_status_reg <= s1_status;
            m_letter_reg <= (s1_status == STATUS_OK) ? tbl_rd_data : 8'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_letter_reg;
    assign m_tuser  = m_status_reg;

    `MTD_ASSERT_SAME(a_letter_zero_on_error, aclk, aresetn,
        m_tvalid && (m_tuser != STATUS_OK), m_tdata == 8'd0)
    `MTD_ASSERT_SAME(a_walk_never_zero, aclk, aresetn,
        1'b1, walk_index_reg != '0)
    `MTD_ASSERT_NEXT(a_sep_returns_to_root, aclk, aresetn,
        accept && is_sep, (walk_index_reg == IDX_W'(1)) && !too_long_reg)
    `MTD_ASSERT_NEXT(a_empty_walk_silent, aclk, aresetn,
        accept && is_sep && (walk_index_reg == IDX_W'(1)) && !too_long_reg && !s1_valid_reg,
        !s1_valid_reg)

endmodule

@@ src/mtd_table.sv @@
// Letter table memory with per-entry valid bits and a registered read port.
module mtd_table
    import mtd_pkg::*;
#(
    parameter int IDX_W = MAX_DEPTH_DEF + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data,
    output logic             rd_hit
);

    localparam int DEPTH = 1 << IDX_W;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

@@ tb/sv/morse_table_decoder_tb.sv @@
// Self-checking testbench for the Morse table decoder over its request and result streams.
`timescale 1ns / 100ps

module morse_table_decoder_tb;
    import mtd_pkg::*;

    localparam int DEPTH         = MAX_DEPTH_DEF;
    localparam int IDX_W         = DEPTH + 1;
    localparam int TABLE_SIZE    = 1 << (DEPTH + 1);
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int DRAIN_EVERY   = 400;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] SYM_UNUSED  = 2'd3;

    typedef struct packed {
        logic [7:0] letter;
        logic [1:0] status;
    } decode_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // symbol, letter, path_bits, path_length, zero pad
    logic [1:0]  s_tuser  = '0;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // decoded_letter
    logic [1:0]  m_tuser;        // status

    decode_result_t pending_letters[$];
    decode_result_t head_result;
    logic [7:0]     letter_mem [TABLE_SIZE];
    bit             entry_ok [TABLE_SIZE];
    logic [DEPTH:0] walk_idx = IDX_W'(1);
    bit             overlong = 1'b0;

    int mismatches    = 0;
    int cycle_count   = 0;
    int rx_count      = 0;
    int item_count    = 0;
    int burst_left    = 0;
    bit sender_bursty = 1'b1;

    always #5 aclk = ~aclk;

    morse_table_decoder #(
        .MAX_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    task automatic predict_decoder(input logic [1:0] mode, input logic [1:0] sym,
                                   input logic [7:0] letter, input logic [5:0] bits,
                                   input logic [2:0] len);
        logic [IDX_W-1:0] pos;
        decode_result_t res;
        case (mode)
            MODE_CLEAR: begin
                foreach (entry_ok[i]) entry_ok[i] = 1'b0;
            end
            MODE_LOAD: begin
                if (len <= DEPTH) begin
                    pos = IDX_W'((1 << len) | (int'(bits) & ((1 << len) - 1)));
                    letter_mem[pos] = letter;
                    entry_ok[pos] = 1'b1;
                end
            end
            MODE_DECODE: begin
                if (sym == SYM_DOT || sym == SYM_DASH) begin
                    if (walk_idx >= (1 << DEPTH)) overlong = 1'b1;
                    else walk_idx = {walk_idx[DEPTH-1:0], sym[0]};
                end else if (sym == SYM_SEP && (walk_idx != 1 || overlong)) begin
                    res.letter = 8'h00;
                    if (overlong) begin
                        res.status = STATUS_TOO_LONG;
                    end else if (!entry_ok[walk_idx]) begin
                        res.status = STATUS_NO_LETTER;
                    end else begin
                        res.status = STATUS_OK;
                        res.letter = letter_mem[walk_idx];
                    end
                    pending_letters.push_back(res);
                    walk_idx = IDX_W'(1);
                    overlong = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [1:0] mode, input logic [1:0] sym,
                                input logic [7:0] letter, input logic [5:0] bits,
                                input logic [2:0] len);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, len, bits, letter, sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_decoder(mode, sym, letter, bits, len);
        if (!(mode == MODE_UNUSED || (mode == MODE_DECODE && sym == SYM_UNUSED)
              || (mode == MODE_LOAD && len > DEPTH)))
            item_count++;
        if (sender_bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(11, 0);
                gap = $urandom_range(6, 1);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_decode(input logic [1:0] sym);
        send_request(MODE_DECODE, sym, 8'($urandom()), 6'($urandom()), 3'($urandom()));
    endtask

    task automatic send_load(input logic [7:0] letter, input logic [5:0] bits,
                             input logic [2:0] len);
        send_request(MODE_LOAD, 2'($urandom()), letter, bits, len);
    endtask

    // The sender holds off here until the result stream has caught up.
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_letters.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [9:0] expv,
                                   input logic [9:0] actv);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in %s: expected %0h, got %0h", field, expv, actv);
    endtask

    task automatic test_empty_walk;
        send_decode(SYM_SEP);
        send_decode(SYM_DASH);
        send_decode(SYM_DASH);
        send_decode(SYM_SEP);
    endtask

    task automatic test_load_and_decode;
        send_load(8'h45, 6'h00, 3'd1);
        send_load(8'hFF, 6'h3F, 3'(DEPTH));
        send_load(8'h00, 6'($urandom()), 3'd0);
        send_load(8'h51, 6'h3F, 3'(DEPTH + 1));
        send_decode(SYM_DOT);
        send_decode(SYM_SEP);
    endtask

    task automatic test_too_long;
        repeat (DEPTH + 1) send_decode(SYM_DASH);
        send_decode(SYM_SEP);
        send_decode(SYM_SEP);
    endtask

    task automatic test_unused_codes;
        send_request(MODE_UNUSED, 2'($urandom()), 8'($urandom()), 6'($urandom()),
                     3'($urandom()));
        send_decode(SYM_UNUSED);
    endtask

    task automatic test_clear;
        send_request(MODE_CLEAR, 2'($urandom()), 8'($urandom()), 6'($urandom()),
                     3'($urandom()));
        send_decode(SYM_DOT);
        send_decode(SYM_SEP);
        wait_for_results();
    endtask

    task automatic test_random_traffic;
        int pick;
        int word_len;
        int next_drain;
        for (int len = 1; len <= DEPTH; len++)
            for (int p = 0; p < (1 << len); p++)
                send_load(8'($urandom()), 6'(p), 3'(len));
        next_drain = item_count + DRAIN_EVERY;
        while (item_count < RANDOM_ITEMS) begin
            sender_bursty = ((item_count / 150) % 3) != 0;
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                word_len = $urandom_range(99, 0);
                if (word_len < 5) word_len = 0;
                else if (word_len < 15) word_len = $urandom_range(DEPTH + 3, DEPTH + 1);
                else word_len = $urandom_range(DEPTH, 1);
                repeat (word_len) send_decode(2'($urandom_range(SYM_DASH, SYM_DOT)));
                send_decode(SYM_SEP);
            end else if (pick < 82) begin
                send_load(8'($urandom()), 6'($urandom()),
                          ($urandom_range(19, 0) == 0) ? 3'd0 : 3'($urandom_range(DEPTH, 1)));
            end else if (pick < 85) begin
                send_request(MODE_CLEAR, 2'($urandom()), 8'($urandom()), 6'($urandom()),
                             3'($urandom()));
            end else if (pick < 94) begin
                send_decode(2'($urandom_range(SYM_SEP, SYM_DOT)));
            end else begin
                case ($urandom_range(2, 0))
                    0: send_request(MODE_UNUSED, 2'($urandom()), 8'($urandom()),
                                    6'($urandom()), 3'($urandom()));
                    1: send_decode(SYM_UNUSED);
                    default: send_load(8'($urandom()), 6'($urandom()), 3'(DEPTH + 1));
                endcase
            end
            if (item_count >= next_drain) begin
                wait_for_results();
                next_drain += DRAIN_EVERY;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_letters.size() == 0) begin
                report_mismatch("unexpected result", 10'h0, {m_tdata, m_tuser});
            end else begin
                head_result = pending_letters.pop_front();
                if (m_tdata !== head_result.letter)
                    report_mismatch("decoded_letter", 10'(head_result.letter), 10'(m_tdata));
                if (m_tuser !== head_result.status)
                    report_mismatch("status", 10'(head_result.status), 10'(m_tuser));
            end
        end
    end

    always @(posedge aclk) begin
        rx_count++;
        case ((rx_count / 257) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(1, 0));
            2: m_tready <= ($urandom_range(3, 0) == 0);
            default: m_tready <= (rx_count % 5) >= 3;
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_walk();
        test_load_and_decode();
        test_too_long();
        test_unused_codes();
        test_clear();
        test_random_traffic();
        wait_for_results();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
